// ===== rtl/skm_pkg.sv =====
// Shared types and codes for the skyline merge unit.
`timescale 1ns / 1ps

package skm_pkg;

	// Width of a coordinate or height.
	localparam int unsigned VAL_W = 32;

	// Request selector codes.
	localparam logic [1:0] FUNC_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] FUNC_LOAD_SECOND = 2'd1;
	localparam logic [1:0] FUNC_MERGE       = 2'd2;

	// Response kind codes.
	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_POINT = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	// Starting value of the running heights and of the last emitted height.
	localparam logic signed [VAL_W-1:0] HEIGHT_START = -32'sd1;

	// One key point of a skyline.
	typedef struct packed {
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] h;
	} point_t;

endpackage

// ===== rtl/skm_if.sv =====
// Valid/ready channel interfaces for the skyline merge requests and responses.
`timescale 1ns / 1ps

interface skm_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [31:0] coord_x;
	logic signed [31:0] height;

	modport source (output valid, output func, output coord_x, output height, input ready);
	modport sink (input valid, input func, input coord_x, input height, output ready);
endinterface

interface skm_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [31:0] out_x;
	logic signed [31:0] out_height;
	logic               dropped;
	logic               last;

	modport source (output valid, output kind, output out_x, output out_height,
		output dropped, output last, input ready);
	modport sink (input valid, input kind, input out_x, input out_height,
		input dropped, input last, output ready);
endinterface

// ===== rtl/skm_store.sv =====
// Point store: one write port and one registered read port.
`timescale 1ns / 1ps

module skm_store #(
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  skm_pkg::point_t wr_pt,
	input  logic [AW-1:0]   rd_addr,
	output skm_pkg::point_t rd_pt
);
	import skm_pkg::*;

	point_t mem [DEPTH];
	point_t rd_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_pt;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign rd_pt = rd_q;

endmodule

// ===== rtl/skyline_merge_unit.sv =====
// Top level of the skyline merge unit: load path, merge sequencer and response register.
`timescale 1ns / 1ps

// Two point stores are loaded one beat per cycle (func 0 and 1) while the
// response side keeps ready high, each load answered by one acknowledge
// beat that flags a point dropped on a full store. A merge beat (func 2)
// starts a two-pointer walk over both stores. Each walk step passes ST_FETCH
// for the registered store read and ST_EVAL for the shared compare step that
// picks the smaller x (both on a tie), updates the running heights and decides
// on a result; it stalls while a new result waits on a pending one and a full
// response register. One result is held back in a pending register so that
// the final beat can carry last; a merge without results answers one empty
// beat. No request is taken while a merge runs. Both counts clear at its end.
module skyline_merge_unit #(
	parameter int MAX_POINTS = 32
) (
	input logic clk,
	input logic arst_n,
	skm_req_if.sink   req,
	skm_rsp_if.source rsp
);
	import skm_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_POINTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EVAL,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic [CW-1:0] ptr_a_q, ptr_b_q;
	logic signed [VAL_W-1:0] h_a_q, h_b_q, last_h_q;
	logic   pend_valid_q;
	point_t pend_q;

	logic               out_valid_q;
	logic [1:0]         out_kind_q;
	logic signed [31:0] out_x_q;
	logic signed [31:0] out_h_q;
	logic               out_drop_q;
	logic               out_last_q;

	// Request handshake and load decode.
	logic slot_free, req_fire, load_a, load_b, full_a, full_b;
	point_t load_pt;

	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && slot_free;
	assign req_fire  = req.valid && req.ready;
	assign full_a    = cnt_a_q >= FULL_CNT;
	assign full_b    = cnt_b_q >= FULL_CNT;
	assign load_a    = req_fire && (req.func == FUNC_LOAD_FIRST) && !full_a;
	assign load_b    = req_fire && (req.func == FUNC_LOAD_SECOND) && !full_b;
	assign load_pt   = '{x: req.coord_x, h: req.height};

	// Point stores.
	point_t rd_a, rd_b;

	skm_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store_a (
		.clk     (clk),
		.wr_en   (load_a),
		.wr_addr (cnt_a_q[AW-1:0]),
		.wr_pt   (load_pt),
		.rd_addr (ptr_a_q[AW-1:0]),
		.rd_pt   (rd_a)
	);

	skm_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store_b (
		.clk     (clk),
		.wr_en   (load_b),
		.wr_addr (cnt_b_q[AW-1:0]),
		.wr_pt   (load_pt),
		.rd_addr (ptr_b_q[AW-1:0]),
		.rd_pt   (rd_b)
	);

	// Shared compare step of the walk.
	logic have_a, have_b, both, a_lt, b_lt, take_a, take_b;
	logic produce, stall;
	logic signed [VAL_W-1:0] nh_a, nh_b, m_h;
	point_t res;

	always_comb begin
		have_a  = ptr_a_q < cnt_a_q;
		have_b  = ptr_b_q < cnt_b_q;
		both    = have_a && have_b;
		a_lt    = rd_a.x < rd_b.x;
		b_lt    = rd_b.x < rd_a.x;
		take_a  = have_a && (!have_b || !b_lt);
		take_b  = have_b && (!have_a || !a_lt);
		nh_a    = (both && take_a) ? rd_a.h : h_a_q;
		nh_b    = (both && take_b) ? rd_b.h : h_b_q;
		m_h     = (nh_a > nh_b) ? nh_a : nh_b;
		res.x   = take_a ? rd_a.x : rd_b.x;
		res.h   = both ? m_h : (take_a ? rd_a.h : rd_b.h);
		produce = both ? (m_h != last_h_q) : (have_a || have_b);
		stall   = produce && pend_valid_q && !slot_free;
	end

	// Sequencer, counts, pending result and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_a_q      <= '0;
			cnt_b_q      <= '0;
			ptr_a_q      <= '0;
			ptr_b_q      <= '0;
			h_a_q        <= HEIGHT_START;
			h_b_q        <= HEIGHT_START;
			last_h_q     <= HEIGHT_START;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_ACK;
			out_x_q      <= '0;
			out_h_q      <= '0;
			out_drop_q   <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.func)
							FUNC_LOAD_FIRST, FUNC_LOAD_SECOND: begin
								out_valid_q <= 1'b1;
								out_kind_q  <= KIND_ACK;
								out_x_q     <= '0;
								out_h_q     <= '0;
								out_last_q  <= 1'b1;
								if (req.func == FUNC_LOAD_FIRST) begin
									out_drop_q <= full_a;
									if (!full_a) begin
										cnt_a_q <= cnt_a_q + 1'b1;
									end
								end else begin
									out_drop_q <= full_b;
									if (!full_b) begin
										cnt_b_q <= cnt_b_q + 1'b1;
									end
								end
							end
							FUNC_MERGE: begin
								ptr_a_q      <= '0;
								ptr_b_q      <= '0;
								h_a_q        <= HEIGHT_START;
								h_b_q        <= HEIGHT_START;
								last_h_q     <= HEIGHT_START;
								pend_valid_q <= 1'b0;
								state_q      <= ST_FETCH;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!(have_a || have_b)) begin
						state_q <= ST_FINISH;
					end else if (!stall) begin
						// Push the held result out, then hold the new one.
						if (produce) begin
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_kind_q  <= KIND_POINT;
								out_x_q     <= pend_q.x;
								out_h_q     <= pend_q.h;
								out_drop_q  <= 1'b0;
								out_last_q  <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_q       <= res;
							if (both) begin
								last_h_q <= m_h;
							end
						end
						h_a_q <= nh_a;
						h_b_q <= nh_b;
						if (take_a) begin
							ptr_a_q <= ptr_a_q + 1'b1;
						end
						if (take_b) begin
							ptr_b_q <= ptr_b_q + 1'b1;
						end
						state_q <= ST_FETCH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= pend_valid_q ? KIND_POINT : KIND_EMPTY;
						out_x_q      <= pend_valid_q ? pend_q.x : '0;
						out_h_q      <= pend_valid_q ? pend_q.h : '0;
						out_drop_q   <= 1'b0;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						cnt_a_q      <= '0;
						cnt_b_q      <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.out_x      = out_x_q;
	assign rsp.out_height = out_h_q;
	assign rsp.dropped    = out_drop_q;
	assign rsp.last       = out_last_q;

	// A store never holds more points than it has entries.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= FULL_CNT) && (cnt_b_q <= FULL_CNT))
		else $error("point count exceeds store depth");

	// The walk pointers never pass the counts.
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ((ptr_a_q <= cnt_a_q) && (ptr_b_q <= cnt_b_q)))
		else $error("walk pointer beyond point count");

	// Counts hold still while a merge walks the stores.
	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |=> ($stable(cnt_a_q) && $stable(cnt_b_q)))
		else $error("point count changed during merge");

	// The close of a merge presents a final beat and clears both counts.
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && slot_free) |=>
		(rsp.valid && rsp.last && cnt_a_q == '0 && cnt_b_q == '0))
		else $error("merge did not close with a final beat");

endmodule
